>>> rtl/lru_pr_pkg.sv
// Shared constants, payload types and cell control struct for the LRU page replacement block.
package lru_pr_pkg;

    localparam int MAX_FRAMES  = 8;
    localparam int PAGE_BITS   = 16;
    localparam int PAGE_NUM_W  = 16;
    localparam int CFG_W       = 4;
    localparam int FCOUNT_W    = 16;
    localparam int CNT_W       = $clog2(MAX_FRAMES + 1);

    localparam logic [CFG_W-1:0] FRAMES_RESET = CFG_W'(3);

    typedef logic [PAGE_BITS-1:0] t_page;
    typedef logic [CNT_W-1:0]     t_count;
    typedef logic [CFG_W-1:0]     t_cfg;

    typedef struct packed {
        logic [PAGE_NUM_W-1:0] page_number;
        logic                  last_reference;
    } t_ref_item;

    typedef struct packed {
        logic                  fault;
        logic                  evicted_valid;
        logic [PAGE_NUM_W-1:0] evicted_page;
        logic [FCOUNT_W-1:0]   fault_count;
    } t_res_item;

    typedef struct packed {
        logic shift;
        logic load;
    } t_cell_ctl;

endpackage

>>> rtl/lru_pr_if.sv
// Handshake channel interfaces for page references, results and the frame count register.
interface lru_pr_ref_if;
    import lru_pr_pkg::*;
    logic      valid;
    logic      ready;
    t_ref_item payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface lru_pr_res_if;
    import lru_pr_pkg::*;
    logic      valid;
    logic      ready;
    t_res_item payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface lru_pr_cfg_if;
    import lru_pr_pkg::*;
    logic valid;
    logic ready;
    t_cfg data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/lru_pr_cell.sv
// One frame cell of the recency chain: holds a page, compares it and takes its neighbor's page.
module lru_pr_cell (
    input  logic                  i_clk,
    input  lru_pr_pkg::t_cell_ctl i_ctl,
    input  lru_pr_pkg::t_page     i_page,
    input  lru_pr_pkg::t_page     i_next,
    input  logic                  i_occupied,
    input  logic                  i_seen,
    output logic                  o_seen,
    output logic                  o_match,
    output lru_pr_pkg::t_page     o_page
);
    import lru_pr_pkg::*;

    t_page r_page;
    t_page n_page;

    assign o_match = i_occupied && (r_page == i_page);
    // The hit flag ripples toward the most recent end, so every cell at or
    // above the hit knows it must close the gap.
    assign o_seen  = i_seen || o_match;
    assign o_page  = r_page;

    always_comb begin
        n_page = r_page;
        if (i_ctl.load) begin
            n_page = i_page;
        end else if (i_ctl.shift) begin
            n_page = i_next;
        end
    end

    always_ff @(posedge i_clk) begin
        r_page <= n_page;
    end

endmodule

>>> rtl/lru_page_replacement_top.sv
// Top level of the LRU page replacement block: recency cell chain, counters and result register.
//
//   Channel   Dir   Payload                                              Transfer
//   i_ref     in    page_number[15:0], last_reference                    valid && ready
//   o_res     out   fault, evicted_valid, evicted_page[15:0], fault_count valid && ready
//   i_cfg     in    frames_in_use[3:0]                                   valid && ready
//
// One reference per cycle while results are drained: all frame cells compare in parallel and the chain
// shifts in the same cycle, so the result lands in the output register in the cycle after the transfer.
// Reset is synchronous and clears the resident count, the fault count and the output
// register, and sets frames_in_use to 3. A new reference is taken while the output
// register is empty or being drained in the same cycle; the config channel is always ready.
module lru_page_replacement_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    lru_pr_ref_if.sink   i_ref,
    lru_pr_res_if.source o_res,
    lru_pr_cfg_if.sink   i_cfg
);
    import lru_pr_pkg::*;

    t_cfg                    r_frames;
    t_count                  r_count;
    t_count                  n_count;
    logic [FCOUNT_W-1:0]     r_faults;
    logic [FCOUNT_W-1:0]     n_faults;
    logic                    r_out_valid;
    t_res_item               r_out;
    t_res_item               n_out;

    t_page                   w_page;
    t_count                  w_cap;
    logic                    w_acc;
    logic                    w_hit;
    logic                    w_full;
    logic                    w_full_miss;
    logic [MAX_FRAMES:0]     w_seen;
    logic [MAX_FRAMES-1:0]   w_match;
    logic [MAX_FRAMES-1:0]   w_occ;
    t_page                   w_cell_page [MAX_FRAMES];
    t_cell_ctl               w_ctl       [MAX_FRAMES];

    assign w_page      = t_page'(i_ref.payload.page_number);
    assign i_ref.ready = !r_out_valid || o_res.ready;
    assign w_acc       = i_ref.valid && i_ref.ready;
    assign i_cfg.ready = 1'b1;

    // Out-of-range frame counts are clamped: zero to one frame, larger counts to the chain length.
    always_comb begin
        if (r_frames == '0) begin
            w_cap = t_count'(1);
        end else if (int'(r_frames) > MAX_FRAMES) begin
            w_cap = t_count'(MAX_FRAMES);
        end else begin
            w_cap = t_count'(r_frames);
        end
    end

    assign w_seen[0]   = 1'b0;
    assign w_hit       = w_seen[MAX_FRAMES];
    assign w_full      = r_count >= w_cap;
    assign w_full_miss = !w_hit && w_full;

    for (genvar gi = 0; gi < MAX_FRAMES; gi++) begin : g_cell
        localparam t_count IDX  = t_count'(gi);
        localparam t_count IDX1 = t_count'(gi + 1);

        assign w_occ[gi] = IDX < r_count;

        // Cells at or above the hit (or all cells on an eviction) below the top resident cell slide down by one;
        // the top resident cell, or the first free one, takes the new page.
        always_comb begin
            w_ctl[gi].shift = w_acc && (IDX1 < r_count) &&
                              (w_hit ? w_seen[gi + 1] : w_full_miss);
            w_ctl[gi].load  = w_acc &&
                              (((IDX1 == r_count) && (w_hit || w_full_miss)) ||
                               ((IDX == r_count) && !w_hit && !w_full));
        end

        lru_pr_cell u_cell (
            .i_clk      (i_clk),
            .i_ctl      (w_ctl[gi]),
            .i_page     (w_page),
            .i_next     ((gi == MAX_FRAMES - 1) ? t_page'(0) : w_cell_page[(gi + 1) % MAX_FRAMES]),
            .i_occupied (w_occ[gi]),
            .i_seen     (w_seen[gi]),
            .o_seen     (w_seen[gi + 1]),
            .o_match    (w_match[gi]),
            .o_page     (w_cell_page[gi])
        );
    end

    always_comb begin
        n_count  = r_count;
        n_faults = r_faults;
        if (!w_hit) begin
            if (r_faults != '1) begin
                n_faults = r_faults + 1'b1;
            end
            if (!w_full) begin
                n_count = r_count + 1'b1;
            end
        end
        n_out.fault         = !w_hit;
        n_out.evicted_valid = w_full_miss;
        n_out.evicted_page  = w_full_miss ? PAGE_NUM_W'(w_cell_page[0]) : '0;
        n_out.fault_count   = n_faults;
        if (i_ref.payload.last_reference) begin
            n_count  = '0;
            n_faults = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frames    <= FRAMES_RESET;
            r_count     <= '0;
            r_faults    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_frames <= i_cfg.data;
            end
            if (w_acc) begin
                r_count     <= n_count;
                r_faults    <= n_faults;
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_out <= n_out;
        end
    end

    assign o_res.valid   = r_out_valid;
    assign o_res.payload = r_out;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_count) <= MAX_FRAMES)
        else $error("resident count exceeds frame chain length");

    a_single_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_match))
        else $error("page resident in more than one frame");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc && i_ref.payload.last_reference |=> (r_count == '0) && (r_faults == '0))
        else $error("state not cleared after last reference");

    a_fill_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc && !w_hit && !w_full && !i_ref.payload.last_reference
        |=> r_count == $past(r_count) + 1'b1)
        else $error("resident count did not grow on a miss with free frames");

    a_evict_is_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.payload.evicted_valid |-> o_res.payload.fault)
        else $error("eviction reported without a fault");
`endif

endmodule

>>> test/tb.sv
// Self-checking testbench for the LRU page replacement block: directed table, then random traffic.
module tb;
    import lru_pr_pkg::*;

    localparam int STALL_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 400;
    localparam int PHASE_ITEMS  = 90;

    typedef enum bit {ROW_REF, ROW_CFG} t_row_kind;

    typedef struct {
        t_row_kind kind;
        t_cfg      frames;
        t_ref_item item;
        bit        typed;
        t_res_item res;
    } t_stim_row;

    logic clk;
    logic rst_n;

    lru_pr_ref_if ref_ch();
    lru_pr_res_if res_ch();
    lru_pr_cfg_if cfg_ch();

    lru_page_replacement_top u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_ref   (ref_ch),
        .o_res   (res_ch),
        .i_cfg   (cfg_ch)
    );

    // Expected value for the row being offered; it travels with the payload.
    logic      row_typed;
    t_res_item row_exp;

    // Own copy of the recency chain, slot 0 least recent.
    t_page                lru_frames [MAX_FRAMES];
    int                   lru_resident = 0;
    logic [FCOUNT_W-1:0]  fault_total  = '0;
    t_cfg                 frames_reg   = FRAMES_RESET;

    t_res_item   pending_results[$];
    t_page       page_pool[$];
    t_stim_row   dir_table[$];

    int  refs_sent      = 0;
    int  results_checked = 0;
    int  mismatches     = 0;
    int  frame_writes   = 0;
    int  strings_closed = 0;
    int  hit_total      = 0;
    int  evict_total    = 0;
    int  stall_cycles   = 0;
    bit  quiet_idle     = 1'b0;
    bit  hold_request   = 1'b0;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic t_res_item predict_reference(t_ref_item item);
        t_page     page;
        int        cap;
        int        n;
        int        hit_at;
        int        i;
        t_res_item r;
        page = item.page_number;
        cap = int'(frames_reg);
        if (cap < 1) cap = 1;
        if (cap > MAX_FRAMES) cap = MAX_FRAMES;
        n = lru_resident;
        hit_at = n;
        r = '0;
        for (i = 0; i < n; i++)
            if (lru_frames[i] == page && hit_at == n) hit_at = i;
        if (hit_at < n) begin
            for (i = hit_at; i + 1 < n; i++) lru_frames[i] = lru_frames[i + 1];
            lru_frames[n - 1] = page;
        end else begin
            r.fault = 1'b1;
            if (fault_total != '1) fault_total++;
            if (n >= cap) begin
                // Only the single oldest page leaves, even when the count was lowered.
                r.evicted_valid = 1'b1;
                r.evicted_page  = lru_frames[0];
                for (i = 0; i + 1 < n; i++) lru_frames[i] = lru_frames[i + 1];
                lru_frames[n - 1] = page;
            end else begin
                lru_frames[n] = page;
                n++;
            end
            lru_resident = n;
        end
        r.fault_count = fault_total;
        if (item.last_reference) begin
            lru_resident = 0;
            fault_total  = '0;
        end
        return r;
    endfunction

    function automatic t_stim_row ref_row(t_page page, bit last);
        t_stim_row row;
        row = '{kind: ROW_REF, frames: '0, item: '{page_number: page, last_reference: last},
                typed: 1'b0, res: '0};
        return row;
    endfunction

    function automatic t_stim_row typed_row(t_page page, bit last, t_res_item res);
        t_stim_row row;
        row = ref_row(page, last);
        row.typed = 1'b1;
        row.res   = res;
        return row;
    endfunction

    function automatic t_stim_row cfg_row(t_cfg value);
        t_stim_row row;
        row = '{kind: ROW_CFG, frames: value, item: '0, typed: 1'b0, res: '0};
        return row;
    endfunction

    function automatic t_page pick_page();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 75) return page_pool[$urandom_range(0, page_pool.size() - 1)];
        if (roll < 95) return t_page'($urandom);
        return roll[0] ? '1 : '0;
    endfunction

    task automatic send_reference(t_ref_item item, bit typed, t_res_item res);
        int gap;
        gap = quiet_idle ? 0 : $urandom_range(0, 13);
        if (gap != 0) begin
            ref_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        ref_ch.valid   <= 1'b1;
        ref_ch.payload <= item;
        row_typed      <= typed;
        row_exp        <= res;
        do @(posedge clk); while (!ref_ch.ready);
        refs_sent++;
    endtask

    task automatic wait_drained();
        ref_ch.valid <= 1'b0;
        while (results_checked != refs_sent) @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_frames(t_cfg value);
        wait_drained();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    // Result side: random back-pressure, plus one long hold-off on request.
    initial begin
        int gap;
        res_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            gap = quiet_idle ? 0 : $urandom_range(0, 13);
            if (gap != 0) begin
                res_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge clk); while (!res_ch.valid);
        end
    end

    // Tracks every transfer: checks results, follows the register, predicts references.
    always @(posedge clk) begin
        t_res_item want;
        if (rst_n) begin
            if (res_ch.valid && res_ch.ready) begin
                if (pending_results.size() == 0) begin
                    $error("result with no reference pending: %p", res_ch.payload);
                    mismatches++;
                end else begin
                    want = pending_results.pop_front();
                    if (res_ch.payload.fault !== want.fault) begin
                        $error("fault: expected %0d, got %0d", want.fault, res_ch.payload.fault);
                        mismatches++;
                    end
                    if (res_ch.payload.evicted_valid !== want.evicted_valid) begin
                        $error("evicted_valid: expected %0d, got %0d",
                               want.evicted_valid, res_ch.payload.evicted_valid);
                        mismatches++;
                    end
                    if (res_ch.payload.evicted_page !== want.evicted_page) begin
                        $error("evicted_page: expected %h, got %h",
                               want.evicted_page, res_ch.payload.evicted_page);
                        mismatches++;
                    end
                    if (res_ch.payload.fault_count !== want.fault_count) begin
                        $error("fault_count: expected %0d, got %0d",
                               want.fault_count, res_ch.payload.fault_count);
                        mismatches++;
                    end
                    if (!want.fault) hit_total++;
                    if (want.evicted_valid) evict_total++;
                end
                results_checked++;
            end
            if (cfg_ch.valid && cfg_ch.ready) begin
                frames_reg = cfg_ch.data;
                frame_writes++;
            end
            if (ref_ch.valid && ref_ch.ready) begin
                want = predict_reference(ref_ch.payload);
                if (row_typed) want = row_exp;
                if (ref_ch.payload.last_reference) strings_closed++;
                pending_results.push_back(want);
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (ref_ch.valid && ref_ch.ready) || (res_ch.valid && res_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready)) begin
            stall_cycles = 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $error("no transfer for %0d cycles, %0d results outstanding",
                   stall_cycles, pending_results.size());
            $display("Verification failed");
            $finish;
        end else begin
            stall_cycles++;
        end
    end

    initial begin
        t_ref_item item;
        int        n_pool;
        int        i;
        rst_n          <= 1'b0;
        ref_ch.valid   <= 1'b0;
        ref_ch.payload <= '0;
        cfg_ch.valid   <= 1'b0;
        cfg_ch.data    <= '0;
        row_typed      <= 1'b0;
        row_exp        <= '0;

        // Typed rows follow the default of three frames from reset.
        dir_table.push_back(typed_row(16'h0000, 1'b0, {1'b1, 1'b0, 16'h0000, 16'd1}));
        dir_table.push_back(typed_row(16'hFFFF, 1'b0, {1'b1, 1'b0, 16'h0000, 16'd2}));
        dir_table.push_back(typed_row(16'h0000, 1'b0, {1'b0, 1'b0, 16'h0000, 16'd2}));
        dir_table.push_back(typed_row(16'h5555, 1'b0, {1'b1, 1'b0, 16'h0000, 16'd3}));
        dir_table.push_back(typed_row(16'hAAAA, 1'b0, {1'b1, 1'b1, 16'hFFFF, 16'd4}));
        dir_table.push_back(typed_row(16'h1234, 1'b1, {1'b1, 1'b1, 16'h0000, 16'd5}));
        dir_table.push_back(typed_row(16'hAAAA, 1'b0, {1'b1, 1'b0, 16'h0000, 16'd1}));
        // A frame count of zero behaves as one.
        dir_table.push_back(cfg_row(4'd0));
        dir_table.push_back(typed_row(16'h8001, 1'b0, {1'b1, 1'b1, 16'hAAAA, 16'd2}));
        dir_table.push_back(typed_row(16'h8001, 1'b0, {1'b0, 1'b0, 16'h0000, 16'd2}));
        dir_table.push_back(cfg_row(4'd15));
        for (i = 1; i <= 7; i++) dir_table.push_back(ref_row(t_page'(i), 1'b0));
        dir_table.push_back(ref_row(16'h0100, 1'b0));
        // Shrink the frame count while eight pages are resident.
        dir_table.push_back(cfg_row(4'd2));
        dir_table.push_back(ref_row(16'h0200, 1'b0));
        dir_table.push_back(ref_row(16'h0003, 1'b0));
        dir_table.push_back(cfg_row(4'd9));
        dir_table.push_back(ref_row(16'hFFFE, 1'b0));
        dir_table.push_back(ref_row(16'h0004, 1'b1));

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_table[k]) begin
            if (dir_table[k].kind == ROW_CFG) write_frames(dir_table[k].frames);
            else send_reference(dir_table[k].item, dir_table[k].typed, dir_table[k].res);
        end

        // One phase per register value; strings usually run across phase boundaries.
        for (int phase = 0; phase < 16; phase++) begin
            write_frames(t_cfg'((phase * 7) % 16));
            quiet_idle = (phase % 4 == 3);
            if (phase == 5) hold_request = 1'b1;
            page_pool.delete();
            n_pool = $urandom_range(2, 12);
            repeat (n_pool) page_pool.push_back(t_page'($urandom));
            repeat (PHASE_ITEMS) begin
                item.page_number    = pick_page();
                item.last_reference = ($urandom_range(0, 39) == 0);
                send_reference(item, 1'b0, '0);
            end
        end

        quiet_idle = 1'b0;
        wait_drained();

        $display("Checked %0d results from %0d references: %0d hits, %0d evictions.",
                 results_checked, refs_sent, hit_total, evict_total);
        $display("%0d frame-count writes over all sixteen register values, %0d strings closed.",
                 frame_writes, strings_closed);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/lru_pr_pkg.sv
rtl/lru_pr_if.sv
rtl/lru_pr_cell.sv
rtl/lru_page_replacement_top.sv
test/tb.sv
